// ===== hdl/adc_oversample_accumulator_top_macros.svh =====
// Assertion macros for the ADC oversampling accumulator.
// Used by adc_oversample_accumulator_top; needs nothing else.
`ifndef ADC_OVERSAMPLE_ACCUMULATOR_TOP_MACROS_SVH
`define ADC_OVERSAMPLE_ACCUMULATOR_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define AOA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define AOA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/aoa_pkg.sv =====
// Shared types, constants and the channel-to-slot map of the ADC
// oversampling accumulator. No dependencies.
`timescale 1ns / 1ps

package aoa_pkg;

    localparam int NUM_SETS_DEF  = 3;
    localparam int NUM_SLOTS_DEF = 5;

    localparam int CMD_W   = 2;
    localparam int CHAN_W  = 8;
    localparam int VALUE_W = 10;
    localparam int RSLOT_W = 3;
    localparam int SUM_W   = 22;
    localparam int MV_W    = 13;
    localparam int OSC_W   = 13;

    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POLL   = 2'd2;

    localparam logic [CHAN_W-1:0] ROUND_CHANNEL = 8'd8;
    localparam logic [OSC_W-1:0]  OSC_RESET     = 13'd1000;
    localparam logic [SUM_W-1:0]  SUM_MAX       = {SUM_W{1'b1}};

    // millivolts = sum * 18 / 10240 = (sum * MV_MUL) >> MV_SHIFT, exact for 22-bit sums.
    localparam int              MV_SHIFT = 36;
    localparam int              MV_MUL_W = 27;
    localparam logic [MV_MUL_W-1:0] MV_MUL = 27'd120795956;

    typedef struct packed {
        logic       hit;
        logic [3:0] slot;
    } t_slot_hit;

    function automatic t_slot_hit channel_slot(input logic [CHAN_W-1:0] ch);
        t_slot_hit r;
        r.hit  = 1'b1;
        r.slot = 4'd0;
        unique case (ch)
            8'd1:    r.slot = 4'd0;
            8'd2:    r.slot = 4'd1;
            8'd6:    r.slot = 4'd2;
            8'd7:    r.slot = 4'd3;
            8'd8:    r.slot = 4'd4;
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/adc_oversample_accumulator_top.sv =====
// Top level of the ADC oversampling accumulator: fill lanes, published
// lanes, round counter and the result register. Depends on aoa_pkg and
// adc_oversample_accumulator_top_macros.svh.
`timescale 1ns / 1ps
`include "adc_oversample_accumulator_top_macros.svh"

// Usage
// The input channel (i_valid/o_ready) carries one command per beat: an ADC
// sample, a slot read of the published set, or a poll for a new set. Reads
// and polls each produce one beat on the output channel (o_valid/i_ready);
// samples produce none. The configuration channel (i_cfg_valid/o_cfg_ready)
// writes the oversample count and is always ready; write it while idle.
// A sample is summed into the fill lanes in the cycle it is accepted; when
// the round counter reaches the oversample count the fill lanes move to the
// published lanes at once and the fill lanes restart from zero.
// A read or poll result appears in the result register in the cycle after its acceptance.
// Throughput: one command per cycle, set by the single result register;
// o_ready drops only while a result waits and i_ready is low, so a stalled
// receiver holds the result and blocks further commands until it is taken.
// Reset (synchronous, active low) zeroes all lane sums and the round counter,
// marks no set published or polled, and loads an oversample count of 1000.
module adc_oversample_accumulator_top #(
    parameter int NUM_SETS  = aoa_pkg::NUM_SETS_DEF,
    parameter int NUM_SLOTS = aoa_pkg::NUM_SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [aoa_pkg::OSC_W-1:0]   i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [aoa_pkg::CMD_W-1:0]   i_cmd,
    input  logic [aoa_pkg::CHAN_W-1:0]  i_adc_channel,
    input  logic [aoa_pkg::VALUE_W-1:0] i_adc_value,
    input  logic [aoa_pkg::RSLOT_W-1:0] i_read_slot,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [aoa_pkg::SUM_W-1:0]   o_sum,
    output logic [aoa_pkg::MV_W-1:0]    o_millivolts,
    output logic                        o_valid_res,
    output logic                        o_new_results
);
    import aoa_pkg::*;

    localparam int SET_W = $clog2(NUM_SETS + 1);
    localparam logic [SET_W-1:0] SET_NONE = {SET_W{1'b1}};
    localparam logic [SET_W-1:0] SET_LAST = SET_W'(NUM_SETS - 1);

    logic [OSC_W-1:0] r_os_count;
    logic [OSC_W-1:0] r_round_cnt, n_round_cnt;
    logic [SET_W-1:0] r_fill_set, n_fill_set;
    logic [SET_W-1:0] r_pub_set, n_pub_set;
    logic [SET_W-1:0] r_poll_set, n_poll_set;
    logic [SUM_W-1:0] r_fill [NUM_SLOTS];
    logic [SUM_W-1:0] n_fill [NUM_SLOTS];
    logic [SUM_W-1:0] r_pub  [NUM_SLOTS];

    logic             r_out_valid, n_out_valid;
    logic [SUM_W-1:0] r_out_sum, n_out_sum;
    logic [MV_W-1:0]  r_out_mv, n_out_mv;
    logic             r_out_vres, n_out_vres;
    logic             r_out_new, n_out_new;

    logic                      in_accept;
    logic                      is_sample;
    logic                      publish;
    logic                      have_set;
    t_slot_hit                 slot_hit;
    logic                      slot_ok;
    logic [SUM_W:0]            add_wide;
    logic [SUM_W-1:0]          rd_sum;
    logic [SUM_W+MV_MUL_W-1:0] mv_prod;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_out_valid || i_ready;
    assign in_accept   = i_valid && o_ready;
    assign is_sample   = in_accept && (i_cmd == CMD_SAMPLE);
    assign have_set    = (r_pub_set != SET_NONE);

    assign slot_hit = channel_slot(i_adc_channel);
    assign slot_ok  = slot_hit.hit && (slot_hit.slot < 4'(NUM_SLOTS));

    always_comb begin
        n_round_cnt = r_round_cnt;
        publish     = 1'b0;
        if (is_sample && (i_adc_channel == ROUND_CHANNEL)) begin
            n_round_cnt = r_round_cnt + OSC_W'(1);
            if (n_round_cnt >= r_os_count) begin
                n_round_cnt = '0;
                publish     = 1'b1;
            end
        end
    end

    // Each lane adds only when the sample targets it, saturating at full scale.
    always_comb begin
        add_wide = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            n_fill[i] = r_fill[i];
            if (is_sample && slot_ok && (slot_hit.slot == 4'(i))) begin
                add_wide  = {1'b0, r_fill[i]} + (SUM_W + 1)'(i_adc_value);
                n_fill[i] = add_wide[SUM_W] ? SUM_MAX : add_wide[SUM_W-1:0];
            end
        end
    end

    always_comb begin
        n_fill_set = r_fill_set;
        n_pub_set  = r_pub_set;
        if (publish) begin
            n_pub_set  = r_fill_set;
            n_fill_set = (r_fill_set == SET_LAST) ? '0 : r_fill_set + SET_W'(1);
        end
    end

    always_comb begin
        rd_sum = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (have_set && (4'(i_read_slot) == 4'(i))) begin
                rd_sum = r_pub[i];
            end
        end
    end

    assign mv_prod = (SUM_W + MV_MUL_W)'(rd_sum) * (SUM_W + MV_MUL_W)'(MV_MUL);

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        n_out_sum   = r_out_sum;
        n_out_mv    = r_out_mv;
        n_out_vres  = r_out_vres;
        n_out_new   = r_out_new;
        n_poll_set  = r_poll_set;
        if (in_accept && (i_cmd == CMD_READ)) begin
            n_out_valid = 1'b1;
            n_out_sum   = rd_sum;
            n_out_mv    = mv_prod[MV_SHIFT +: MV_W];
            n_out_vres  = have_set;
            n_out_new   = 1'b0;
        end else if (in_accept && (i_cmd == CMD_POLL)) begin
            n_out_valid = 1'b1;
            n_out_sum   = '0;
            n_out_mv    = '0;
            n_out_vres  = have_set;
            n_out_new   = (r_poll_set != r_pub_set);
            n_poll_set  = r_pub_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_os_count  <= OSC_RESET;
            r_round_cnt <= '0;
            r_fill_set  <= '0;
            r_pub_set   <= SET_NONE;
            r_poll_set  <= SET_NONE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_fill[i] <= '0;
                r_pub[i]  <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_os_count <= i_cfg_data;
            end
            r_round_cnt <= n_round_cnt;
            r_fill_set  <= n_fill_set;
            r_pub_set   <= n_pub_set;
            r_poll_set  <= n_poll_set;
            r_out_valid <= n_out_valid;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_fill[i] <= publish ? '0 : n_fill[i];
                if (publish) begin
                    r_pub[i] <= n_fill[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_sum  <= n_out_sum;
        r_out_mv   <= n_out_mv;
        r_out_vres <= n_out_vres;
        r_out_new  <= n_out_new;
    end

    assign o_valid       = r_out_valid;
    assign o_sum         = r_out_sum;
    assign o_millivolts  = r_out_mv;
    assign o_valid_res   = r_out_vres;
    assign o_new_results = r_out_new;

    `AOA_ASSERT_NOW(a_fill_not_pub, i_clk, i_rst_n, r_pub_set != SET_NONE, r_fill_set != r_pub_set, "fill set equals published set")
    `AOA_ASSERT_NOW(a_fill_range, i_clk, i_rst_n, 1'b1, r_fill_set <= SET_LAST, "fill set index out of range")
    `AOA_ASSERT_NEXT(a_pub_sticky, i_clk, i_rst_n, r_pub_set != SET_NONE, r_pub_set != SET_NONE, "published set lost")
    `AOA_ASSERT_NEXT(a_round_clear, i_clk, i_rst_n, publish, r_round_cnt == '0, "round counter not cleared on publish")
    `AOA_ASSERT_NOW(a_new_needs_set, i_clk, i_rst_n, r_out_valid && r_out_new, r_out_vres && (r_out_sum == '0), "new-set report without published set")

endmodule

// ===== test/adc_oversample_accumulator_top_tb.sv =====
// Self-checking testbench for adc_oversample_accumulator_top: random and directed
// commands against a built-in predictor of the three rotating accumulator sets.
// Depends on aoa_pkg and the RTL of the top level only.
`timescale 1ns / 1ps

module adc_oversample_accumulator_top_tb;
    import aoa_pkg::*;

    localparam int NSETS  = NUM_SETS_DEF;
    localparam int NSLOTS = NUM_SLOTS_DEF;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] NO_SET = 2'd3;
    localparam int STUCK_LIMIT = 2000;
    localparam int HOLD_OFF = 3;
    localparam logic [CHAN_W-1:0] MAPPED_CH [NSLOTS] = '{8'd1, 8'd2, 8'd6, 8'd7, 8'd8};

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [CHAN_W-1:0]  chan;
        logic [VALUE_W-1:0] level;
        logic [RSLOT_W-1:0] slot;
    } adc_cmd_t;

    typedef struct packed {
        logic [SUM_W-1:0] total;
        logic [MV_W-1:0]  mv;
        logic             valid_res;
        logic             new_results;
    } reading_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [OSC_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [CMD_W-1:0] i_cmd = CMD_SAMPLE;
    logic [CHAN_W-1:0] i_adc_channel = '0;
    logic [VALUE_W-1:0] i_adc_value = '0;
    logic [RSLOT_W-1:0] i_read_slot = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [SUM_W-1:0] o_sum;
    logic [MV_W-1:0] o_millivolts;
    logic o_valid_res;
    logic o_new_results;

    adc_oversample_accumulator_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_adc_channel (i_adc_channel),
        .i_adc_value   (i_adc_value),
        .i_read_slot   (i_read_slot),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_sum         (o_sum),
        .o_millivolts  (o_millivolts),
        .o_valid_res   (o_valid_res),
        .o_new_results (o_new_results)
    );

    always #5 i_clk = ~i_clk;

    // Predicted accumulator state.
    logic [SUM_W-1:0] acc_sum [NSETS][NSLOTS];
    logic [OSC_W-1:0] rounds = '0;
    logic [OSC_W-1:0] osc_model = OSC_RESET;
    logic [1:0] fill_idx = 2'd0;
    logic [1:0] pub_idx = NO_SET;
    logic [1:0] polled_idx = NO_SET;

    adc_cmd_t cmd_feed [$];
    reading_t readings_due [$];
    int cmd_beats = 0;
    int res_beats = 0;
    int items_pushed = 0;
    int errors = 0;
    int stuck = 0;
    bit hurry = 1'b0;

    initial begin
        foreach (acc_sum[s, k]) acc_sum[s][k] = '0;
    end

    function automatic int draw_wait();
        return hurry ? 0 : $urandom_range(0, 11);
    endfunction

    // Applies one accepted command to the predicted state and queues the
    // reading it produces, if any.
    task automatic apply_command(input adc_cmd_t c);
        int slot_hit;
        longint unsigned grown;
        reading_t r;
        slot_hit = -1;
        r = '0;
        if (c.cmd == CMD_SAMPLE) begin
            for (int k = 0; k < NSLOTS; k++) begin
                if (MAPPED_CH[k] == c.chan) slot_hit = k;
            end
            if (slot_hit >= 0) begin
                grown = acc_sum[fill_idx][slot_hit] + c.level;
                acc_sum[fill_idx][slot_hit] = (grown > SUM_MAX) ? SUM_MAX : grown[SUM_W-1:0];
            end
            if (c.chan == ROUND_CHANNEL) begin
                rounds = rounds + OSC_W'(1);
                if (rounds >= osc_model) begin
                    rounds = '0;
                    pub_idx = fill_idx;
                    fill_idx = (fill_idx == NSETS - 1) ? 2'd0 : fill_idx + 2'd1;
                    for (int k = 0; k < NSLOTS; k++) acc_sum[fill_idx][k] = '0;
                end
            end
        end else if (c.cmd == CMD_READ || c.cmd == CMD_POLL) begin
            r.valid_res = (pub_idx != NO_SET);
            if (c.cmd == CMD_READ) begin
                if (r.valid_res && c.slot < NSLOTS) r.total = acc_sum[pub_idx][c.slot];
            end else if (polled_idx != pub_idx) begin
                polled_idx = pub_idx;
                r.new_results = 1'b1;
            end
            r.mv = MV_W'((longint'(r.total) * 18) / 10240);
            readings_due.push_back(r);
        end
    endtask

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    // Monitor: sample every handshake at the rising edge.
    always @(posedge i_clk) begin
        reading_t want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                res_beats++;
                if (readings_due.size() == 0) begin
                    $error("result beat with nothing expected: sum %0d", o_sum);
                    errors++;
                end else begin
                    want = readings_due.pop_front();
                    check_field("sum", want.total, o_sum);
                    check_field("millivolts", want.mv, o_millivolts);
                    check_field("valid_res", want.valid_res, o_valid_res);
                    check_field("new_results", want.new_results, o_new_results);
                end
            end
            if (i_valid && o_ready) begin
                apply_command({i_cmd, i_adc_channel, i_adc_value, i_read_slot});
                cmd_beats++;
            end
            if (i_cfg_valid && o_cfg_ready) osc_model = i_cfg_data;
            if ((o_valid && i_ready) || (i_valid && o_ready) || (i_cfg_valid && o_cfg_ready))
                stuck = 0;
            else
                stuck++;
            if (stuck >= STUCK_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Command driver: presents queued commands after a random gap.
    adc_cmd_t feed_cur;
    bit feed_live = 1'b0;
    int feed_issued = 0;
    int feed_gap = 0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (feed_live && cmd_beats == feed_issued) begin
                feed_live = 1'b0;
                feed_gap = draw_wait();
            end
            if (!feed_live) begin
                if (feed_gap > 0) begin
                    feed_gap--;
                end else if (cmd_feed.size() > 0) begin
                    feed_cur = cmd_feed.pop_front();
                    feed_live = 1'b1;
                    feed_issued++;
                    i_cmd <= feed_cur.cmd;
                    i_adc_channel <= feed_cur.chan;
                    i_adc_value <= feed_cur.level;
                    i_read_slot <= feed_cur.slot;
                end
            end
            i_valid <= feed_live;
        end
    end

    // Result receiver: stalls a random number of cycles after each beat.
    int res_seen = 0;
    int ready_wait = 0;

    always @(negedge i_clk) begin
        if (res_beats != res_seen) begin
            res_seen = res_beats;
            ready_wait = draw_wait();
        end
        if (ready_wait > 0) begin
            ready_wait--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [CHAN_W-1:0] chan,
                             input logic [VALUE_W-1:0] level,
                             input logic [RSLOT_W-1:0] slot);
        cmd_feed.push_back({cmd, chan, level, slot});
        items_pushed++;
    endtask

    function automatic adc_cmd_t random_cmd();
        adc_cmd_t c;
        int pick;
        c.cmd = CMD_W'($urandom_range(0, 3));
        c.chan = CHAN_W'($urandom_range(0, 255));
        c.level = VALUE_W'($urandom_range(0, 1023));
        c.slot = RSLOT_W'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            c.cmd = CMD_SAMPLE;
            c.chan = MAPPED_CH[$urandom_range(0, NSLOTS - 1)];
        end else if (pick < 65) begin
            c.cmd = CMD_SAMPLE;
        end else if (pick < 82) begin
            c.cmd = CMD_READ;
            if ($urandom_range(0, 4) != 0) c.slot = RSLOT_W'($urandom_range(0, NSLOTS - 1));
        end else if (pick < 94) begin
            c.cmd = CMD_POLL;
        end else begin
            c.cmd = CMD_UNUSED;
        end
        if ($urandom_range(0, 7) == 0) c.level = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
        return c;
    endfunction

    // Returns at a falling edge once every command is taken and every
    // reading has arrived, then waits the given extra falling edges for a trailing sample.
    task automatic wait_drained(input int extra);
        while (cmd_beats != items_pushed || readings_due.size() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_count(input logic [OSC_W-1:0] count);
        wait_drained(HOLD_OFF);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= count;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [OSC_W-1:0] phase_counts [8];
        adc_cmd_t c;
        phase_counts = '{13'd2, 13'd1, 13'd4096, 13'd0, 13'd3, 13'd8191, 13'd1, 13'd6};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Nothing published yet: reads are zero with valid_res low.
        queue_cmd(CMD_READ, 8'd0, 10'd0, 3'd0);
        queue_cmd(CMD_READ, 8'd255, 10'd1023, 3'd7);
        queue_cmd(CMD_POLL, 8'd0, 10'd0, 3'd0);
        queue_cmd(CMD_UNUSED, 8'd255, 10'd1023, 3'd7);
        queue_cmd(CMD_SAMPLE, 8'd0, 10'd1023, 3'd0);
        queue_cmd(CMD_SAMPLE, 8'd255, 10'd0, 3'd7);
        queue_cmd(CMD_POLL, 8'd0, 10'd0, 3'd0);

        // One round per set, then read every slot, in range and out of it.
        write_count(13'd1);
        queue_cmd(CMD_SAMPLE, 8'd1, 10'd1023, 3'd0);
        queue_cmd(CMD_SAMPLE, 8'd2, 10'd0, 3'd0);
        queue_cmd(CMD_SAMPLE, 8'd6, 10'd512, 3'd0);
        queue_cmd(CMD_SAMPLE, 8'd7, 10'd1, 3'd0);
        queue_cmd(CMD_SAMPLE, 8'd3, 10'd1023, 3'd0);
        queue_cmd(CMD_SAMPLE, ROUND_CHANNEL, 10'd1023, 3'd0);
        for (int k = 0; k < 8; k++) queue_cmd(CMD_READ, 8'd0, 10'd0, RSLOT_W'(k));
        queue_cmd(CMD_POLL, 8'd0, 10'd0, 3'd0);
        queue_cmd(CMD_POLL, 8'd0, 10'd0, 3'd0);
        queue_cmd(CMD_UNUSED, 8'd0, 10'd0, 3'd0);

        // A count of zero publishes every round.
        write_count(13'd0);
        queue_cmd(CMD_SAMPLE, ROUND_CHANNEL, 10'd7, 3'd0);
        queue_cmd(CMD_READ, 8'd0, 10'd0, 3'd4);
        queue_cmd(CMD_POLL, 8'd0, 10'd0, 3'd0);

        // Pile full-scale samples into slot 0 under a count too large to
        // publish, then lower the count below the rounds already seen.
        write_count(13'd8191);
        hurry = 1'b1;
        repeat (40) queue_cmd(CMD_SAMPLE, 8'd1, 10'd1023, 3'd0);
        repeat (3) queue_cmd(CMD_SAMPLE, ROUND_CHANNEL, 10'd1023, 3'd0);
        queue_cmd(CMD_POLL, 8'd0, 10'd0, 3'd0);
        write_count(13'd1);
        hurry = 1'b0;
        queue_cmd(CMD_SAMPLE, ROUND_CHANNEL, 10'd0, 3'd0);
        queue_cmd(CMD_READ, 8'd0, 10'd0, 3'd0);
        queue_cmd(CMD_READ, 8'd0, 10'd0, 3'd4);
        queue_cmd(CMD_POLL, 8'd0, 10'd0, 3'd0);

        for (int p = 0; p < 8; p++) begin
            write_count(phase_counts[p]);
            hurry = (p % 3 == 2);
            repeat (55) begin
                c = random_cmd();
                queue_cmd(c.cmd, c.chan, c.level, c.slot);
            end
        end

        wait_drained(5);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
